/* rtl/stcag_pkg.sv */
`default_nettype none

package stcag_pkg;

  // Fixed field widths of the register file and the result item.
  localparam int LANE_W   = 16;
  localparam int OFF_W    = 40;
  localparam int RANK_W   = 3;
  localparam int EB_W     = 7;
  localparam int WORD_W   = 32;
  localparam int PACK_W   = 64;
  localparam int KIND_W   = 2;

  // Layout kinds; the fourth code has no meaning and is reported as an error.
  localparam logic [KIND_W-1:0] KIND_CONTIG  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STRIDED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CONCAT  = 2'd2;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_KIND     = 3'd0,
    REG_RANK     = 3'd1,
    REG_EB       = 3'd2,
    REG_SRC_BASE = 3'd3,
    REG_DST_BASE = 3'd4,
    REG_EXTENTS  = 3'd5,
    REG_SSTRIDES = 3'd6,
    REG_DSTRIDES = 3'd7
  } cfg_reg_t;

  // Per-item flags that travel with the offsets down the pipeline.
  typedef struct packed {
    logic valid_res;
    logic err;
    logic last;
    logic pc;
  } item_tag_t;

endpackage

`default_nettype wire

/* rtl/stcag_stage.sv */
`default_nettype none

// One pipeline stage per dimension. For strided layouts it adds index times
// stride on both sides; otherwise it performs one Horner step of the
// row-major source offset and adds the destination index times stride.
module stcag_stage
  import stcag_pkg::*;
#(
  parameter int MAX_RANK = 4,
  parameter int DIM_BITS = 16,
  parameter int STAGE    = 0
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire [KIND_W-1:0]                 kind,
  input  wire [RANK_W-1:0]                 rank,
  input  wire [LANE_W-1:0]                 src_stride,
  input  wire [LANE_W-1:0]                 dst_stride,
  input  wire                              up_valid,
  output logic                             up_ready,
  input  wire item_tag_t                   up_tag,
  input  wire [MAX_RANK-1:0][DIM_BITS-1:0] up_cnt,
  input  wire [MAX_RANK-1:0][DIM_BITS-1:0] up_ps,
  input  wire [MAX_RANK-1:0][DIM_BITS:0]   up_dpos,
  input  wire [OFF_W-1:0]                  up_sacc,
  input  wire                              up_sbig,
  input  wire [OFF_W-1:0]                  up_dacc,
  output logic                             dn_valid,
  input  wire                              dn_ready,
  output item_tag_t                        dn_tag,
  output logic [MAX_RANK-1:0][DIM_BITS-1:0] dn_cnt,
  output logic [MAX_RANK-1:0][DIM_BITS-1:0] dn_ps,
  output logic [MAX_RANK-1:0][DIM_BITS:0]   dn_dpos,
  output logic [OFF_W-1:0]                 dn_sacc,
  output logic                             dn_sbig,
  output logic [OFF_W-1:0]                 dn_dacc
);

  localparam int SP_W = OFF_W + LANE_W;
  localparam int DP_W = DIM_BITS + 1 + LANE_W;

  logic                   used;
  logic                   strided;
  logic [DIM_BITS-1:0]    idx;
  logic [OFF_W-1:0]       src_a;
  logic [LANE_W-1:0]      src_b;
  logic [OFF_W-1:0]       src_add;
  logic [SP_W-1:0]        src_prod;
  logic [SP_W:0]          src_sum;
  logic [DIM_BITS:0]      dst_a;
  logic [DP_W-1:0]        dst_prod;
  logic [OFF_W-1:0]       dst_sum;
  logic [OFF_W-1:0]       sacc_next;
  logic                   sbig_next;
  logic [OFF_W-1:0]       dacc_next;

  assign used    = RANK_W'(STAGE) < rank;
  assign strided = (kind == KIND_STRIDED);
  assign idx     = up_cnt[STAGE];

  // Source side: one shared multiplier, operands chosen by layout kind.
  assign src_a    = strided ? OFF_W'(idx) : up_sacc;
  assign src_b    = strided ? src_stride : LANE_W'(up_ps[STAGE]);
  assign src_add  = strided ? up_sacc : OFF_W'(idx);
  assign src_prod = SP_W'(src_a) * SP_W'(src_b);
  assign src_sum  = {1'b0, src_prod} + (SP_W + 1)'(src_add);

  // Destination side: index (shifted by the split for the second piece)
  // times the destination stride.
  assign dst_a    = strided ? {1'b0, idx} : up_dpos[STAGE];
  assign dst_prod = DP_W'(dst_a) * DP_W'(dst_stride);
  assign dst_sum  = up_dacc + OFF_W'(dst_prod);

  // Dimensions beyond the rank leave the sums untouched. A source carry past
  // the offset range is remembered as overflow; later factors are nonzero.
  assign sacc_next = used ? src_sum[OFF_W-1:0] : up_sacc;
  assign sbig_next = up_sbig | (used & (|src_sum[SP_W:OFF_W]));
  assign dacc_next = used ? dst_sum : up_dacc;

  assign up_ready = !dn_valid || dn_ready;

  // Stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_tag  <= up_tag;
      dn_cnt  <= up_cnt;
      dn_ps   <= up_ps;
      dn_dpos <= up_dpos;
      dn_sacc <= sacc_next;
      dn_sbig <= sbig_next;
      dn_dacc <= dacc_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/strided_tensor_copy_address_gen_core.sv */
// Strided tensor copy address generator.
//
// Configuration is written through the cfg channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data); the user must write it only while no item is in
// flight, which the block does not enforce. cfg_ready is always high.
// Each item on the input channel (in_valid, in_ready, restart) requests the
// next element of the copy walk. Exactly one result item per input item
// leaves on the output channel (out_valid, out_ready) in request order.
//
// Throughput is one item per clock while the receiver does not stall. The
// walk position is updated in the cycle an item is taken; the offsets then
// pass the decode register, one stage per dimension (MAX_RANK stages, one
// multiply per side each) and byte scaling into the output register.
//
// Reset clears the configuration (element size 1, all else zero), the walk
// position and the pipeline. When the receiver stalls, the result holds in
// the output register and the stages behind it keep filling; input is
// refused only once every stage is occupied.
`default_nettype none

module strided_tensor_copy_address_gen_core
  import stcag_pkg::*;
#(
  parameter int MAX_RANK = 4,
  parameter int DIM_BITS = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                restart,
  output logic               out_valid,
  input  wire                out_ready,
  output logic               valid_res,
  output logic               source_select,
  output logic [OFF_W-1:0]   source_byte_offset,
  output logic [OFF_W-1:0]   dest_byte_offset,
  output logic               last_element,
  output logic               config_error,
  output logic               offset_overflow,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [2:0]         cfg_index,
  input  wire  [PACK_W-1:0]  cfg_data
);

  localparam logic [RANK_W-1:0] MAX_RANK_C = RANK_W'(MAX_RANK);
  localparam int BYTE_W = OFF_W + EB_W;

  // Configuration registers.
  logic [KIND_W-1:0] layout_kind;
  logic [RANK_W-1:0] tensor_rank;
  logic [EB_W-1:0]   element_bytes;
  logic [WORD_W-1:0] src_base_or_axis;
  logic [WORD_W-1:0] dst_base_or_split;
  logic [PACK_W-1:0] extents_packed;
  logic [PACK_W-1:0] src_strides_packed;
  logic [PACK_W-1:0] dst_strides_packed;

  // Walk state.
  logic [MAX_RANK-1:0][DIM_BITS-1:0] dim_cnt;
  logic                              piece_select;
  logic                              walk_started;

  // Walk decode.
  logic [MAX_RANK-1:0][DIM_BITS-1:0] ext;
  logic [MAX_RANK-1:0][DIM_BITS-1:0] ps0;
  logic [MAX_RANK-1:0][DIM_BITS-1:0] ps1;
  logic [MAX_RANK-1:0][DIM_BITS-1:0] ps;
  logic [MAX_RANK-1:0][DIM_BITS-1:0] cnt;
  logic [MAX_RANK-1:0][DIM_BITS-1:0] cnt_next;
  logic [MAX_RANK-1:0][DIM_BITS:0]   dpos;
  logic [MAX_RANK-1:0]               used;
  logic [MAX_RANK-1:0]               is_axis;
  logic [DIM_BITS-1:0]               axis_ext;
  logic [DIM_BITS-1:0]               split_n;
  logic                              is_concat;
  logic                              cfg_err;
  logic                              empty;
  logic                              nonempty0;
  logic                              nonempty1;
  logic                              in_piece;
  logic                              keep;
  logic                              pc;
  logic                              pc_next;
  logic                              wrap_all;
  logic                              walk_last;
  logic                              in_fire;

  // Pipeline links: index 0 is the decode register, index MAX_RANK feeds
  // the byte scaling stage.
  logic                              stg_vld  [MAX_RANK+1];
  logic                              stg_rdy  [MAX_RANK+1];
  item_tag_t                         stg_tag  [MAX_RANK+1];
  logic [MAX_RANK-1:0][DIM_BITS-1:0] stg_cnt  [MAX_RANK+1];
  logic [MAX_RANK-1:0][DIM_BITS-1:0] stg_ps   [MAX_RANK+1];
  logic [MAX_RANK-1:0][DIM_BITS:0]   stg_dpos [MAX_RANK+1];
  logic [OFF_W-1:0]                  stg_sacc [MAX_RANK+1];
  logic                              stg_sbig [MAX_RANK+1];
  logic [OFF_W-1:0]                  stg_dacc [MAX_RANK+1];

  // Byte scaling.
  logic [OFF_W-1:0]  d_elem;
  logic              d_big;
  logic [BYTE_W-1:0] s_bytes;
  logic [BYTE_W-1:0] d_bytes;
  logic              ovf;
  item_tag_t         fin_tag;

  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      layout_kind        <= KIND_CONTIG;
      tensor_rank        <= '0;
      element_bytes      <= EB_W'(1);
      src_base_or_axis   <= '0;
      dst_base_or_split  <= '0;
      extents_packed     <= '0;
      src_strides_packed <= '0;
      dst_strides_packed <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_KIND:     layout_kind        <= cfg_data[KIND_W-1:0];
        REG_RANK:     tensor_rank        <= cfg_data[RANK_W-1:0];
        REG_EB:       element_bytes      <= cfg_data[EB_W-1:0];
        REG_SRC_BASE: src_base_or_axis   <= cfg_data[WORD_W-1:0];
        REG_DST_BASE: dst_base_or_split  <= cfg_data[WORD_W-1:0];
        REG_EXTENTS:  extents_packed     <= cfg_data;
        REG_SSTRIDES: src_strides_packed <= cfg_data;
        REG_DSTRIDES: dst_strides_packed <= cfg_data;
        default: ;
      endcase
    end
  end

  // Settings checks and the extents of both concat pieces.
  assign is_concat = (layout_kind == KIND_CONCAT);
  assign axis_ext  = extents_packed[LANE_W * src_base_or_axis[1:0] +: DIM_BITS];
  assign split_n   = dst_base_or_split[DIM_BITS-1:0];
  assign cfg_err   = (tensor_rank > MAX_RANK_C)
                  || (layout_kind != KIND_CONTIG && layout_kind != KIND_STRIDED
                      && layout_kind != KIND_CONCAT)
                  || (is_concat && ((src_base_or_axis >= WORD_W'(tensor_rank))
                      || (dst_base_or_split > WORD_W'(axis_ext))));
  assign nonempty0 = !is_concat || (split_n != '0);
  assign nonempty1 = is_concat && (axis_ext != split_n);

  always_comb begin
    empty = (tensor_rank == '0);
    for (int d = 0; d < MAX_RANK; d++) begin
      ext[d]     = extents_packed[LANE_W*d +: DIM_BITS];
      used[d]    = RANK_W'(d) < tensor_rank;
      is_axis[d] = is_concat && (src_base_or_axis == WORD_W'(d));
      ps0[d]     = is_axis[d] ? split_n : ext[d];
      ps1[d]     = is_axis[d] ? ext[d] - split_n : ext[d];
      if (used[d] && ext[d] == '0) begin
        empty = 1'b1;
      end
    end
  end

  // Position of this element: the held one, or the first of the walk when
  // restarting, unstarted, or when the held one no longer fits its piece.
  always_comb begin
    in_piece = 1'b1;
    for (int d = 0; d < MAX_RANK; d++) begin
      if (used[d] && dim_cnt[d] >= (piece_select ? ps1[d] : ps0[d])) begin
        in_piece = 1'b0;
      end
    end
    keep = walk_started && !restart && (piece_select ? nonempty1 : nonempty0) && in_piece;
    pc   = keep ? piece_select : !nonempty0;
    for (int d = 0; d < MAX_RANK; d++) begin
      cnt[d]  = keep ? dim_cnt[d] : '0;
      ps[d]   = pc ? ps1[d] : ps0[d];
      dpos[d] = {1'b0, cnt[d]} + ((pc && is_axis[d]) ? {1'b0, split_n} : '0);
    end
  end

  // Advance the multi-index, last axis fastest, then move between pieces.
  always_comb begin
    logic              carry;
    logic [DIM_BITS:0] inc;
    carry = 1'b1;
    for (int d = MAX_RANK - 1; d >= 0; d--) begin
      inc         = {1'b0, cnt[d]} + (DIM_BITS + 1)'(1);
      cnt_next[d] = cnt[d];
      if (used[d] && carry) begin
        if (inc >= {1'b0, ps[d]}) begin
          cnt_next[d] = '0;
        end else begin
          cnt_next[d] = inc[DIM_BITS-1:0];
          carry       = 1'b0;
        end
      end
    end
    wrap_all  = carry;
    walk_last = 1'b0;
    pc_next   = pc;
    if (wrap_all) begin
      if (!pc && nonempty1) begin
        pc_next = 1'b1;
      end else begin
        walk_last = 1'b1;
        pc_next   = !nonempty0;
      end
    end
  end

  assign in_ready = !stg_vld[0] || stg_rdy[0];
  assign in_fire  = in_valid && in_ready;

  // Walk state update on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_cnt      <= '0;
      piece_select <= 1'b0;
      walk_started <= 1'b0;
    end else if (in_fire) begin
      if (cfg_err || empty) begin
        walk_started <= 1'b0;
      end else begin
        dim_cnt      <= cnt_next;
        piece_select <= pc_next;
        walk_started <= 1'b1;
      end
    end
  end

  // Decode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_vld[0] <= 1'b0;
    end else if (in_ready) begin
      stg_vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_tag[0].valid_res <= !cfg_err && !empty;
      stg_tag[0].err       <= cfg_err;
      stg_tag[0].last      <= !cfg_err && !empty && walk_last;
      stg_tag[0].pc        <= !cfg_err && !empty && pc;
      stg_cnt[0]           <= cnt;
      stg_ps[0]            <= ps;
      stg_dpos[0]          <= dpos;
      stg_sacc[0]          <= (layout_kind == KIND_STRIDED) ? OFF_W'(src_base_or_axis) : '0;
      stg_sbig[0]          <= 1'b0;
      stg_dacc[0]          <= (layout_kind == KIND_STRIDED) ? OFF_W'(dst_base_or_split) : '0;
    end
  end

  // One offset stage per dimension.
  for (genvar g = 0; g < MAX_RANK; g++) begin : g_dim
    stcag_stage #(
      .MAX_RANK (MAX_RANK),
      .DIM_BITS (DIM_BITS),
      .STAGE    (g)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .kind       (layout_kind),
      .rank       (tensor_rank),
      .src_stride (src_strides_packed[LANE_W*g +: LANE_W]),
      .dst_stride (dst_strides_packed[LANE_W*g +: LANE_W]),
      .up_valid   (stg_vld[g]),
      .up_ready   (stg_rdy[g]),
      .up_tag     (stg_tag[g]),
      .up_cnt     (stg_cnt[g]),
      .up_ps      (stg_ps[g]),
      .up_dpos    (stg_dpos[g]),
      .up_sacc    (stg_sacc[g]),
      .up_sbig    (stg_sbig[g]),
      .up_dacc    (stg_dacc[g]),
      .dn_valid   (stg_vld[g+1]),
      .dn_ready   (stg_rdy[g+1]),
      .dn_tag     (stg_tag[g+1]),
      .dn_cnt     (stg_cnt[g+1]),
      .dn_ps      (stg_ps[g+1]),
      .dn_dpos    (stg_dpos[g+1]),
      .dn_sacc    (stg_sacc[g+1]),
      .dn_sbig    (stg_sbig[g+1]),
      .dn_dacc    (stg_dacc[g+1])
    );
  end

  // Byte scaling; the contiguous layout reuses the source offset.
  assign fin_tag = stg_tag[MAX_RANK];
  assign d_elem  = (layout_kind == KIND_CONTIG) ? stg_sacc[MAX_RANK] : stg_dacc[MAX_RANK];
  assign d_big   = (layout_kind == KIND_CONTIG) && stg_sbig[MAX_RANK];
  assign s_bytes = BYTE_W'(stg_sacc[MAX_RANK]) * BYTE_W'(element_bytes);
  assign d_bytes = BYTE_W'(d_elem) * BYTE_W'(element_bytes);
  assign ovf     = stg_sbig[MAX_RANK] || d_big
                || (|s_bytes[BYTE_W-1:OFF_W]) || (|d_bytes[BYTE_W-1:OFF_W]);

  assign stg_rdy[MAX_RANK] = !out_valid || out_ready;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stg_rdy[MAX_RANK]) begin
      out_valid <= stg_vld[MAX_RANK];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_rdy[MAX_RANK] && stg_vld[MAX_RANK]) begin
      valid_res          <= fin_tag.valid_res;
      config_error       <= fin_tag.err;
      source_select      <= fin_tag.pc;
      last_element       <= fin_tag.last;
      source_byte_offset <= fin_tag.valid_res ? s_bytes[OFF_W-1:0] : '0;
      dest_byte_offset   <= fin_tag.valid_res ? d_bytes[OFF_W-1:0] : '0;
      offset_overflow    <= fin_tag.valid_res && ovf;
    end
  end

endmodule

`default_nettype wire

/* rtl/stcag_checker.sv */
`default_nettype none

// Port-level checks on the result channel of the address generator.
module stcag_checker (
  input wire        clk,
  input wire        rst,
  input wire        out_valid,
  input wire        out_ready,
  input wire        valid_res,
  input wire        source_select,
  input wire [39:0] source_byte_offset,
  input wire [39:0] dest_byte_offset,
  input wire        last_element,
  input wire        config_error,
  input wire        offset_overflow
);

  // A stalled result item keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid
      && $stable({valid_res, source_select, source_byte_offset, dest_byte_offset,
                  last_element, config_error, offset_overflow}))
    else $error("result item changed while stalled");

  // An item with no element has no offsets or flags but config_error.
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> !source_select && source_byte_offset == 40'd0
      && dest_byte_offset == 40'd0 && !last_element && !offset_overflow)
    else $error("fields set on an item without an element");

  // Bad settings never describe an element.
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && config_error |-> !valid_res)
    else $error("element given despite a settings error");

  // The pipeline is empty after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present straight after reset");

endmodule

bind strided_tensor_copy_address_gen_core stcag_checker u_stcag_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .valid_res          (valid_res),
  .source_select      (source_select),
  .source_byte_offset (source_byte_offset),
  .dest_byte_offset   (dest_byte_offset),
  .last_element       (last_element),
  .config_error       (config_error),
  .offset_overflow    (offset_overflow)
);

`default_nettype wire
